// ===== sv/gci_pkg.sv =====
// Shared types and constants for the grid cell interpolator.
// Used by gci_round_sat and grid_cell_interpolator; no dependencies.
`timescale 1ns / 1ps

package gci_pkg;

    // Interpolation method codes held in the mode register.
    typedef enum logic [1:0] {
        MODE_BILIN  = 2'd0,
        MODE_MSL    = 2'd1,
        MODE_BIQUAD = 2'd2,
        MODE_ALTBQ  = 2'd3
    } t_mode;

    // Width of the exact accumulator that feeds the rounding stage.
    localparam int unsigned ACC_W = 150;

    // Rounded and saturated result.
    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_result;

endpackage

// ===== sv/grid_cell_interpolator.sv =====
// Top level of the grid cell interpolator: an eight-stage pipeline for three methods.
// Depends on gci_pkg and gci_round_sat.
//
// Usage:
// Each input item carries nine signed Q16.16 samples and two unsigned Q2.16
// coordinates on the slave stream. Bilinear and MSL use samples 0 to 3 as the
// cell corners; biquadratic uses all nine as a row-major 3x3 patch. Each item
// gives exactly one result item on the master stream: the value in tdata and
// the saturation flag in tuser.
// The mode register is written through i_cfg_wr_en and i_cfg_wr_data and must
// only change while no item is in flight; reset selects bilinear.
// The pipeline has eight register stages. One item is accepted every cycle
// while the receiver does not stall; every wide product is split into partial
// products that the following stage sums.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_s_tready falls; nothing is lost or repeated. Reset clears all valid bits.
`timescale 1ns / 1ps

module grid_cell_interpolator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_wr_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // sample_0..sample_8 (32 bits each), x_frac (18), y_frac (18), 4 zero bits
    input  logic [327:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // interp_value (32 bits)
    output logic [31:0]  o_m_tdata,
    // saturated (1 bit)
    output logic         o_m_tuser
);
    import gci_pkg::*;

    localparam logic signed [41:0] POLY_NINE = 42'sd38654705664;

    t_mode r_mode;
    logic  en;
    logic  r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6, r_vld7, r_vld8;

    // Stage 1 registers.
    logic signed [31:0] r1_s [9];
    logic signed [18:0] r1_x, r1_y, r1_ax, r1_ay;
    logic signed [37:0] r1_w [4];
    logic signed [37:0] r1_sqx, r1_sqax, r1_sqy, r1_sqay, r1_tx, r1_ty;
    logic signed [32:0] r1_d0 [3];
    logic signed [33:0] r1_dd [3];

    // Stage 2 registers.
    logic signed [69:0] r2_p [4];
    logic signed [41:0] r2_poly [4];
    logic signed [73:0] r2_sq [4];
    logic signed [72:0] r2_row [3];
    logic signed [31:0] r2_s [4];
    logic signed [18:0] r2_y;
    logic signed [37:0] r2_ty;

    // Stage 3 registers.
    logic signed [71:0]  r3_bil;
    logic signed [67:0]  r3_pa [4][3];
    logic signed [73:0]  r3_yd0;
    logic signed [74:0]  r3_ydd;
    logic signed [72:0]  r3_r0;
    logic signed [31:0]  r3_s [4];
    logic signed [18:0]  r3_y;
    logic signed [37:0]  r3_ty;

    // Stage 4 registers.
    logic signed [71:0]  r4_bil;
    logic signed [115:0] r4_wt [4];
    logic signed [31:0]  r4_s [4];
    logic signed [72:0]  r4_r0;
    logic signed [56:0]  r4_pd [2];
    logic signed [63:0]  r4_pe [3];

    // Stage 5 registers.
    logic signed [71:0]  r5_bil;
    logic signed [61:0]  r5_qp [4][4];
    logic signed [114:0] r5_bq;

    // Stage 6 and 7 registers.
    logic signed [71:0]      r6_bil;
    logic signed [147:0]     r6_q [4];
    logic signed [114:0]     r6_bq;
    logic signed [ACC_W-1:0] r7_acc;

    // Output registers.
    logic [31:0] r_value;
    logic        r_sat;

    logic signed [31:0] in_s [9];
    logic signed [18:0] in_x, in_y, in_ax, in_ay;
    logic signed [18:0] c_a [4];
    logic signed [18:0] c_b [4];
    logic signed [37:0] c_sqa [4];
    logic signed [37:0] c_sqb [4];
    logic signed [ACC_W-1:0] msl_sum;
    t_result rs;

    // The pipeline moves whenever the output register is free or being taken.
    assign en         = ~r_vld8 | i_m_tready;
    assign o_s_tready = en;

    // Unpack the input item.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            in_s[k] = $signed(i_s_tdata[32*k +: 32]);
        end
        in_x  = $signed({1'b0, i_s_tdata[305:288]});
        in_y  = $signed({1'b0, i_s_tdata[323:306]});
        in_ax = 19'sd65536 - in_x;
        in_ay = 19'sd65536 - in_y;
    end

    // Corner arguments in counter-clockwise order: (1-x,1-y), (x,1-y), (x,y), (1-x,y).
    always_comb begin
        c_a[0] = r1_ax; c_b[0] = r1_ay; c_sqa[0] = r1_sqax; c_sqb[0] = r1_sqay;
        c_a[1] = r1_x;  c_b[1] = r1_ay; c_sqa[1] = r1_sqx;  c_sqb[1] = r1_sqay;
        c_a[2] = r1_x;  c_b[2] = r1_y;  c_sqa[2] = r1_sqx;  c_sqb[2] = r1_sqy;
        c_a[3] = r1_ax; c_b[3] = r1_y;  c_sqa[3] = r1_sqax; c_sqb[3] = r1_sqy;
    end

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BILIN;
        end else if (i_cfg_wr_en) begin
            r_mode <= t_mode'(i_cfg_wr_data);
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0; r_vld2 <= 1'b0; r_vld3 <= 1'b0; r_vld4 <= 1'b0;
            r_vld5 <= 1'b0; r_vld6 <= 1'b0; r_vld7 <= 1'b0; r_vld8 <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_s_tvalid;
            r_vld2 <= r_vld1; r_vld3 <= r_vld2; r_vld4 <= r_vld3;
            r_vld5 <= r_vld4; r_vld6 <= r_vld5; r_vld7 <= r_vld6;
            r_vld8 <= r_vld7;
        end
    end

    // Stage 1: coordinate products, squares and the row differences of the patch.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r1_s[k] <= in_s[k];
            end
            r1_x <= in_x; r1_y <= in_y; r1_ax <= in_ax; r1_ay <= in_ay;
            r1_w[0] <= 38'(in_ax) * 38'(in_ay);
            r1_w[1] <= 38'(in_x)  * 38'(in_ay);
            r1_w[2] <= 38'(in_x)  * 38'(in_y);
            r1_w[3] <= 38'(in_ax) * 38'(in_y);
            r1_sqx  <= 38'(in_x)  * 38'(in_x);
            r1_sqax <= 38'(in_ax) * 38'(in_ax);
            r1_sqy  <= 38'(in_y)  * 38'(in_y);
            r1_sqay <= 38'(in_ay) * 38'(in_ay);
            r1_tx   <= -(38'(in_x) * 38'(in_ax));
            r1_ty   <= -(38'(in_y) * 38'(in_ay));
            for (int k = 0; k < 3; k++) begin
                r1_d0[k] <= 33'(in_s[3*k+1]) - 33'(in_s[3*k]);
                r1_dd[k] <= 34'(in_s[3*k+2]) - (34'(in_s[3*k+1]) <<< 1) + 34'(in_s[3*k]);
            end
        end
    end

    // Stage 2: bilinear products, MSL polynomial and square products, row steps.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r2_p[k]    <= 70'(r1_w[k]) * 70'(r1_s[k]);
                r2_poly[k] <= POLY_NINE - 42'sd6 * (42'(c_a[k]) <<< 16)
                              - 42'sd6 * (42'(c_b[k]) <<< 16) + 42'sd4 * 42'(r1_w[k]);
                r2_sq[k]   <= 74'(c_sqa[k]) * 74'(c_sqb[k]);
                r2_s[k]    <= r1_s[k];
            end
            for (int k = 0; k < 3; k++) begin
                r2_row[k] <= (73'(r1_s[3*k]) <<< 33)
                             + ((73'(r1_x) * 73'(r1_d0[k])) <<< 17)
                             + 73'(r1_tx) * 73'(r1_dd[k]);
            end
            r2_y  <= r1_y;
            r2_ty <= r1_ty;
        end
    end

    // Stage 3: bilinear sum, partial products of the MSL weights, column
    // differences of the row results. The square product is cut into two
    // unsigned 25-bit slices and a signed top slice.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_bil <= 72'(r2_p[0]) + 72'(r2_p[1]) + 72'(r2_p[2]) + 72'(r2_p[3]);
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 2; j++) begin
                    r3_pa[k][j] <= 68'($signed({1'b0, r2_sq[k][25*j +: 25]}))
                                   * 68'(r2_poly[k]);
                end
                r3_pa[k][2] <= 68'($signed(r2_sq[k][73:50])) * 68'(r2_poly[k]);
                r3_s[k]     <= r2_s[k];
            end
            r3_yd0 <= 74'(r2_row[1]) - 74'(r2_row[0]);
            r3_ydd <= 75'(r2_row[2]) - (75'(r2_row[1]) <<< 1) + 75'(r2_row[0]);
            r3_r0  <= r2_row[0];
            r3_y   <= r2_y;
            r3_ty  <= r2_ty;
        end
    end

    // Stage 4: MSL weights from their slices, partial products of the step along y.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r4_wt[k] <= 116'(r3_pa[k][0]) + (116'(r3_pa[k][1]) <<< 25)
                            + (116'(r3_pa[k][2]) <<< 50);
                r4_s[k]  <= r3_s[k];
            end
            r4_pd[0] <= 57'($signed({1'b0, r3_yd0[36:0]})) * 57'(r3_y);
            r4_pd[1] <= 57'($signed(r3_yd0[73:37])) * 57'(r3_y);
            r4_pe[0] <= 64'($signed({1'b0, r3_ydd[24:0]})) * 64'(r3_ty);
            r4_pe[1] <= 64'($signed({1'b0, r3_ydd[49:25]})) * 64'(r3_ty);
            r4_pe[2] <= 64'($signed(r3_ydd[74:50])) * 64'(r3_ty);
            r4_r0    <= r3_r0;
            r4_bil   <= r3_bil;
        end
    end

    // Stage 5: partial products of the weighted MSL corners, step along y.
    // Each weight is cut into three unsigned 29-bit slices and a signed top slice.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r5_qp[k][j] <= 62'($signed({1'b0, r4_wt[k][29*j +: 29]}))
                                   * 62'(r4_s[k]);
                end
                r5_qp[k][3] <= 62'($signed(r4_wt[k][115:87])) * 62'(r4_s[k]);
            end
            r5_bq  <= (115'(r4_r0) <<< 33)
                      + ((115'(r4_pd[0]) + (115'(r4_pd[1]) <<< 37)) <<< 17)
                      + 115'(r4_pe[0]) + (115'(r4_pe[1]) <<< 25)
                      + (115'(r4_pe[2]) <<< 50);
            r5_bil <= r4_bil;
        end
    end

    // Stage 6: weighted MSL corners from their slices.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r6_q[k] <= 148'(r5_qp[k][0]) + (148'(r5_qp[k][1]) <<< 29)
                           + (148'(r5_qp[k][2]) <<< 58) + (148'(r5_qp[k][3]) <<< 87);
            end
            r6_bil <= r5_bil;
            r6_bq  <= r5_bq;
        end
    end

    assign msl_sum = ACC_W'(r6_q[0]) + ACC_W'(r6_q[1]) + ACC_W'(r6_q[2]) + ACC_W'(r6_q[3]);

    // Stage 7: select the accumulator of the active method.
    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_mode)
                MODE_BILIN: r7_acc <= ACC_W'(r6_bil);
                MODE_MSL:   r7_acc <= msl_sum;
                default:    r7_acc <= ACC_W'(r6_bq);
            endcase
        end
    end

    gci_round_sat u_round_sat (
        .i_acc  (r7_acc),
        .i_mode (r_mode),
        .o_res  (rs)
    );

    // Stage 8: output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_value <= rs.value;
            r_sat   <= rs.sat;
        end
    end

    assign o_m_tvalid = r_vld8;
    assign o_m_tdata  = r_value;
    assign o_m_tuser  = r_sat;

endmodule

// ===== sv/gci_round_sat.sv =====
// Rounds the exact accumulator to Q16.16 and saturates it to 32 bits.
// Depends on gci_pkg for the mode codes, the accumulator width and the result type.
`timescale 1ns / 1ps

module gci_round_sat (
    input  logic signed [gci_pkg::ACC_W-1:0] i_acc,
    input  gci_pkg::t_mode                   i_mode,
    output gci_pkg::t_result                 o_res
);
    import gci_pkg::*;

    logic signed [ACC_W-1:0] v;
    logic                    fits;

    // Add one half of the output step, then floor by the method's scale.
    always_comb begin
        case (i_mode)
            MODE_BILIN: v = (i_acc + (ACC_W'(1) <<< 31)) >>> 32;
            MODE_MSL:   v = (i_acc + (ACC_W'(1) <<< 95)) >>> 96;
            default:    v = (i_acc + (ACC_W'(1) <<< 65)) >>> 66;
        endcase
    end

    // Clamp when the upper bits are not a sign extension of bit 31.
    assign fits = (v[ACC_W-1:31] == {(ACC_W-31){v[31]}});
    assign o_res.value = fits ? v[31:0] : (v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign o_res.sat   = ~fits;

endmodule

// ===== sim/grid_cell_interpolator_tb.sv =====
// Self-checking testbench for grid_cell_interpolator: directed table, then random items.
// Expected values come from an exact wide-integer predictor; depends on gci_pkg.
`timescale 1ns / 1ps

module grid_cell_interpolator_tb;
    import gci_pkg::*;

    typedef logic signed [255:0] t_wide;

    // One input item: nine samples (sample_0 lowest) and two coordinates.
    typedef struct packed {
        logic [17:0]      y;
        logic [17:0]      x;
        logic [8:0][31:0] smp;
    } t_point;

    // A row of the directed table; a typed-in result is used where known.
    typedef struct {
        t_mode       mode;
        t_point      pt;
        logic        known;
        logic [31:0] want_value;
        logic        want_sat;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [1:0]   i_cfg_wr_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [327:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [31:0]  o_m_tdata;
    logic         o_m_tuser;

    t_result expected_q[$];
    t_mode   cur_mode;
    int      snd_idle;
    int      rcv_idle;
    int      mismatches;
    t_row    rows[$];

    grid_cell_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety limit on the whole run.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Quadratic step by forward differences at Q.16 position t; scaled by 2^33.
    function automatic t_wide quad_fd(t_wide t, t_wide f0, t_wide f1, t_wide f2);
        t_wide d0;
        t_wide dd;
        d0 = f1 - f0;
        dd = (f2 - f1) - d0;
        return (f0 <<< 33) + ((t <<< 17) * d0) + (t * (t - 65536) * dd);
    endfunction

    // MSL corner weight for Q.16 arguments; scaled by 2^96.
    function automatic t_wide msl_w(t_wide a, t_wide b);
        t_wide poly;
        poly = (t_wide'(9) <<< 32) - ((a * 6) <<< 16) - ((b * 6) <<< 16) + a * b * 4;
        return a * a * b * b * poly;
    endfunction

    // Exact interpolation, then round half up and saturate to Q16.16.
    function automatic t_result interpolate(t_mode mode, t_point pt);
        t_wide   s[9];
        t_wide   xv, yv, ax, ay, acc, one, r;
        int      shift;
        t_result res;
        for (int i = 0; i < 9; i++) s[i] = signed'(pt.smp[i]);
        xv = pt.x;
        yv = pt.y;
        ax = 65536 - xv;
        ay = 65536 - yv;
        one = 1;
        case (mode)
            MODE_BILIN: begin
                acc = ax * ay * s[0] + xv * ay * s[1] + xv * yv * s[2] + ax * yv * s[3];
                shift = 32;
            end
            MODE_MSL: begin
                acc = msl_w(ax, ay) * s[0] + msl_w(xv, ay) * s[1]
                    + msl_w(xv, yv) * s[2] + msl_w(ax, yv) * s[3];
                shift = 96;
            end
            default: begin
                acc = quad_fd(yv, quad_fd(xv, s[0], s[1], s[2]),
                              quad_fd(xv, s[3], s[4], s[5]),
                              quad_fd(xv, s[6], s[7], s[8]));
                shift = 66;
            end
        endcase
        r = (acc + (one <<< (shift - 1))) >>> shift;
        if (r > t_wide'(32'sh7FFF_FFFF)) begin
            res.value = 32'h7FFF_FFFF;
            res.sat = 1'b1;
        end else if (r < -t_wide'(64'sh8000_0000)) begin
            res.value = 32'h8000_0000;
            res.sat = 1'b1;
        end else begin
            res.value = r[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [17:0] rand_coord();
        case ($urandom_range(9))
            0: return 18'd0;
            1: return 18'd65536;
            2: return 18'd131072;
            3: return 18'($urandom_range(0, 262143));
            default: return 18'($urandom_range(0, 131072));
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point pt;
        for (int i = 0; i < 9; i++) pt.smp[i] = rand_sample();
        pt.x = rand_coord();
        pt.y = rand_coord();
        return pt;
    endfunction

    // Receiver side: random stalls at the falling edge.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: value %h sat %b", o_m_tdata, o_m_tuser);
            end else begin
                t_result want;
                want = expected_q.pop_front();
                if (want.value !== o_m_tdata || want.sat !== o_m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %h sat %b, got value %h sat %b",
                                 want.value, want.sat, o_m_tdata, o_m_tuser);
                end
            end
        end
    end

    // Wait for the pipeline to drain, then write the mode register.
    task automatic write_mode(t_mode mode);
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_mode = mode;
    endtask

    // Present one item from a falling edge and hold it until it is accepted.
    task automatic send_point(t_point pt, logic known, logic [31:0] val, logic sat);
        t_result want;
        while ($urandom_range(99) < snd_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, pt};
        want = interpolate(cur_mode, pt);
        if (known) begin
            want.value = val;
            want.sat = sat;
        end
        #1;
        while (!o_s_tready) begin
            @(negedge i_clk);
            #1;
        end
        expected_q.push_back(want);
        @(negedge i_clk);
    endtask

    // Directed rows: corner hits, saturation both ways, extreme fields.
    task automatic build_table();
        t_row   row;
        t_point pt;
        for (int i = 0; i < 9; i++) pt.smp[i] = 32'h0001_0000 * (i + 1) + 32'h1234 * i;
        row.known = 1'b1;
        row.mode = MODE_BILIN;
        pt.x = 0;      pt.y = 0;      row.pt = pt; row.want_value = pt.smp[0];
        row.want_sat = 0; rows.push_back(row);
        pt.x = 65536;  pt.y = 0;      row.pt = pt; row.want_value = pt.smp[1]; rows.push_back(row);
        pt.x = 65536;  pt.y = 65536;  row.pt = pt; row.want_value = pt.smp[2]; rows.push_back(row);
        pt.x = 0;      pt.y = 65536;  row.pt = pt; row.want_value = pt.smp[3]; rows.push_back(row);
        // Extrapolation past the cell drives the value beyond the positive bound.
        pt.smp[0] = 32'h8000_0000; pt.smp[1] = 32'h7FFF_FFFF;
        pt.x = 131072; pt.y = 0; row.pt = pt; row.want_value = 32'h7FFF_FFFF;
        row.want_sat = 1; rows.push_back(row);
        pt.smp[0] = 32'h7FFF_FFFF; pt.smp[1] = 32'h8000_0000;
        row.pt = pt; row.want_value = 32'h8000_0000; rows.push_back(row);
        // Rows from here are checked against the predictor unless a result is typed in.
        row.known = 1'b0;
        for (int m = 0; m < 4; m++) begin
            row.mode = t_mode'(m);
            for (int i = 0; i < 9; i++) pt.smp[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            pt.x = 18'h3FFFF; pt.y = 18'h3FFFF; row.pt = pt; rows.push_back(row);
            for (int i = 0; i < 9; i++) pt.smp[i] = 32'hFFFF_FFFF;
            pt.x = 32768; pt.y = 98304; row.pt = pt; rows.push_back(row);
            pt = rand_point(); row.pt = pt; rows.push_back(row);
            pt.x = 0; pt.y = 0; row.pt = pt; row.known = 1'b1;
            row.want_value = pt.smp[0]; row.want_sat = 0; rows.push_back(row);
            row.known = 1'b0;
        end
        // The far corner of the patch in biquadratic mode.
        pt = rand_point(); pt.x = 131072; pt.y = 131072;
        row.mode = MODE_BIQUAD; row.pt = pt; row.known = 1'b1;
        row.want_value = pt.smp[8]; row.want_sat = 0; rows.push_back(row);
    endtask

    // Main stimulus sequence.
    initial begin
        t_mode phase_mode[10] = '{MODE_MSL, MODE_BILIN, MODE_BIQUAD, MODE_ALTBQ, MODE_BIQUAD,
                                  MODE_MSL, MODE_BILIN, MODE_BIQUAD, MODE_MSL, MODE_BILIN};
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 2'd0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        cur_mode      = MODE_BILIN;
        snd_idle      = 14;
        rcv_idle      = 82;
        mismatches    = 0;
        build_table();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part; the first rows rely on the reset mode.
        foreach (rows[i]) begin
            if (rows[i].mode != cur_mode) write_mode(rows[i].mode);
            send_point(rows[i].pt, rows[i].known, rows[i].want_value, rows[i].want_sat);
        end

        // Random part in phases of mode and idling profile.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 4) begin
                snd_idle = 82;
                rcv_idle = 14;
            end else if (ph == 7) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_mode(phase_mode[ph]);
            for (int n = 0; n < 142; n++) begin
                if (ph == 0 && n == 70) begin
                    i_s_tvalid <= 1'b0;
                    while (expected_q.size() != 0) @(negedge i_clk);
                end
                send_point(rand_point(), 1'b0, 32'h0, 1'b0);
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for the pipeline latency.
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
